@@ src/enfa_pkg.sv @@
// Shared types and constants of the lambda-NFA acceptor.
package enfa_pkg;

  localparam int STATE_W     = 4;
  localparam int SLOT_W      = 5;
  localparam int SYM_W       = 8;
  localparam int MODE_W      = 2;
  localparam int SET_OUT_W   = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - SET_OUT_W - 2;

  localparam logic [MODE_W-1:0] MODE_EDGE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEGIN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CONSUME = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT = 2'd1;

  // Input beat layout, lowest field last
  typedef struct packed {
    logic              pad;
    logic [SYM_W-1:0]  symbol;
    logic              edge_enable;
    logic              edge_lambda;
    logic [SYM_W-1:0]  edge_symbol;
    logic [STATE_W-1:0] edge_target;
    logic [STATE_W-1:0] edge_source;
    logic [SLOT_W-1:0] edge_slot;
  } in_item_t;

  typedef struct packed {
    logic load_edge;
    logic load_begin;
    logic load_move;
    logic close_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic changed;
  } sts_t;

endpackage

@@ src/epsilon_nfa_acceptor.sv @@
// Top level of the lambda-NFA acceptor: sequencer plus datapath.
//
//  channel | dir | handshake              | beat contents
//  in_     | in  | in_tvalid / in_tready  | tuser: mode; tdata: edge item or symbol
//  out_    | out | out_tvalid / out_tready| tdata: accepted, active_set, dead
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item at a time. An edge write or unused mode goes from accept to the hand-off
// state; begin and consume first run the lambda-closure passes that add states (at
// most NUM_STATES), one pass over the whole edge table a cycle. Synchronous reset
// clears the edge table valid bits, the active set, the config registers and the
// sequencer state. A held result does not stop the next item being taken; a
// finished item waits for the result register before the one after it is accepted.
module epsilon_nfa_acceptor #(
  parameter int NUM_STATES = 16,
  parameter int NUM_EDGES  = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [4:0] edge_slot, [8:5] edge_source, [12:9] edge_target, [20:13] edge_symbol,
  // [21] edge_lambda, [22] edge_enable, [30:23] symbol, [31] zero
  input  logic [enfa_pkg::IN_TDATA_W-1:0] in_tdata,
  // [1:0] mode
  input  logic [enfa_pkg::MODE_W-1:0]     in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] accepted, [16:1] active_set, [17] dead, [23:18] zero
  output logic [enfa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [enfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [enfa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import enfa_pkg::*;

  cmd_t     cmd;
  sts_t     sts;
  in_item_t in_item;

  assign in_item   = in_item_t'(in_tdata);
  assign cfg_ready = 1'b1;

  enfa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .sts        (sts),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  enfa_dp #(
    .NUM_STATES (NUM_STATES),
    .NUM_EDGES  (NUM_EDGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .in_item   (in_item),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

@@ src/enfa_ctrl.sv @@
// Sequencer of the lambda-NFA acceptor: accept, closure passes, result hand-off.
module enfa_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [enfa_pkg::MODE_W-1:0] in_mode,
  input  enfa_pkg::sts_t             sts,
  output enfa_pkg::cmd_t             cmd,
  output logic                       out_tvalid,
  input  logic                       out_tready
);
  import enfa_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLOSE = 2'd1;
  localparam logic [1:0] S_DONE  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            MODE_EDGE: begin
              cmd.load_edge = 1'b1;
              state_nxt     = S_DONE;
            end
            MODE_BEGIN: begin
              cmd.load_begin = 1'b1;
              state_nxt      = S_CLOSE;
            end
            MODE_CONSUME: begin
              cmd.load_move = 1'b1;
              state_nxt     = S_CLOSE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_CLOSE: begin
        // one pass over all lambda edges; stop once the set stops growing
        if (sts.changed) begin
          cmd.close_step = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result beat raised outside the hand-off state");

  a_close_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLOSE && !sts.changed) |=> state_r == S_DONE)
    else $error("closure finished but sequencer did not move on");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r)
    else $error("stalled result beat dropped");

endmodule

@@ src/enfa_dp.sv @@
// Datapath of the lambda-NFA acceptor: edge table, active set, config and result registers.
module enfa_dp #(
  parameter int NUM_STATES = 16,
  parameter int NUM_EDGES  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [enfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [enfa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  enfa_pkg::cmd_t                 cmd,
  input  enfa_pkg::in_item_t             in_item,
  output enfa_pkg::sts_t                 sts,
  output logic [enfa_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import enfa_pkg::*;

  logic [NUM_EDGES-1:0]  valid_r;
  logic [NUM_EDGES-1:0]  lam_r;
  logic [STATE_W-1:0]    src_r [NUM_EDGES];
  logic [STATE_W-1:0]    tgt_r [NUM_EDGES];
  logic [SYM_W-1:0]      sym_r [NUM_EDGES];

  logic [NUM_STATES-1:0] src_hot [NUM_EDGES];
  logic [NUM_STATES-1:0] tgt_hot [NUM_EDGES];

  logic [NUM_STATES-1:0] set_r, set_nxt;
  logic [NUM_STATES-1:0] start_hot;
  logic [NUM_STATES-1:0] move_set;
  logic [NUM_STATES-1:0] lam_set;
  logic [SET_OUT_W-1:0]  shown;

  logic [STATE_W-1:0]    start_r;
  logic [SET_OUT_W-1:0]  accept_r;

  logic                  accepted_r;
  logic [SET_OUT_W-1:0]  active_r;
  logic                  dead_r;

  // Decode states to one-hot; states beyond the automaton decode to nothing
  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
    for (genvar j = 0; j < NUM_STATES; j++) begin : g_bit
      assign src_hot[e][j] = (32'(src_r[e]) == j);
      assign tgt_hot[e][j] = (32'(tgt_r[e]) == j);
    end
  end

  for (genvar j = 0; j < NUM_STATES; j++) begin : g_start
    assign start_hot[j] = (32'(start_r) == j);
  end

  if (NUM_STATES >= SET_OUT_W) begin : g_shown_cut
    assign shown = set_r[SET_OUT_W-1:0];
  end else begin : g_shown_ext
    assign shown = {{(SET_OUT_W - NUM_STATES){1'b0}}, set_r};
  end

  always_comb begin
    move_set = '0;
    lam_set  = '0;
    for (int e = 0; e < NUM_EDGES; e++) begin
      if (valid_r[e] && !lam_r[e] && (sym_r[e] == in_item.symbol) &&
          (|(src_hot[e] & set_r))) begin
        move_set = move_set | tgt_hot[e];
      end
      if (valid_r[e] && lam_r[e] && (|(src_hot[e] & set_r))) begin
        lam_set = lam_set | tgt_hot[e];
      end
    end
  end

  assign sts.changed = |(lam_set & ~set_r);

  always_comb begin
    set_nxt = set_r;
    if (cmd.load_begin) begin
      set_nxt = start_hot;
    end else if (cmd.load_move) begin
      set_nxt = move_set;
    end else if (cmd.close_step) begin
      set_nxt = set_r | lam_set;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r    <= '0;
      valid_r  <= '0;
      start_r  <= '0;
      accept_r <= '0;
    end else begin
      set_r <= set_nxt;
      for (int e = 0; e < NUM_EDGES; e++) begin
        if (cmd.load_edge && (32'(in_item.edge_slot) == e)) begin
          valid_r[e] <= in_item.edge_enable;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_START:  start_r  <= cfg_data[STATE_W-1:0];
          CFG_ACCEPT: accept_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Edge payload; slots beyond the table match no entry and are dropped
  always_ff @(posedge clk) begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      if (cmd.load_edge && (32'(in_item.edge_slot) == e)) begin
        lam_r[e] <= in_item.edge_lambda;
        src_r[e] <= in_item.edge_source;
        tgt_r[e] <= in_item.edge_target;
        sym_r[e] <= in_item.edge_symbol;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      accepted_r <= |(shown & accept_r);
      active_r   <= shown;
      dead_r     <= (set_r == '0);
    end
  end

  assign out_tdata = {{OUT_PAD_W{1'b0}}, dead_r, active_r, accepted_r};

  a_closure_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.close_step |=> ((($past(set_r)) & ~set_r) == '0))
    else $error("closure pass dropped an active state");

  a_edge_keeps_set: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_edge |=> $stable(set_r))
    else $error("edge write disturbed the active set");

  a_far_slot_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_edge && (32'(in_item.edge_slot) >= NUM_EDGES)) |=> $stable(valid_r))
    else $error("write beyond the edge table changed an entry");

endmodule

@@ tb/epsilon_nfa_acceptor_tb.sv @@
// Self-checking testbench for the lambda-NFA acceptor: directed and random words.
`timescale 1ns / 1ps

module epsilon_nfa_acceptor_tb;
  import enfa_pkg::*;

  localparam int NUM_STATES = 16;
  localparam int NUM_EDGES  = 32;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic               valid;
    logic               lambda;
    logic [STATE_W-1:0] src;
    logic [STATE_W-1:0] dst;
    logic [SYM_W-1:0]   sym;
  } edge_rec_t;

  // Matches out_tdata[17:0]
  typedef struct packed {
    logic                 dead;
    logic [SET_OUT_W-1:0] active_set;
    logic                 accepted;
  } verdict_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // edge_slot, edge_source, edge_target, edge_symbol,
                                      // edge_lambda, edge_enable, symbol, zero
  logic [MODE_W-1:0]      in_tuser;   // mode
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // accepted, active_set, dead, zero
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Predictor state
  edge_rec_t            edge_tbl [NUM_EDGES];
  logic [STATE_W-1:0]   start_reg;
  logic [SET_OUT_W-1:0] accept_reg;
  logic [SET_OUT_W-1:0] cur_set;

  verdict_t pending_verdicts [$];
  int       err_count;
  int       burst_left;
  logic [SYM_W-1:0] alphabet [4];

  epsilon_nfa_acceptor #(
    .NUM_STATES(NUM_STATES),
    .NUM_EDGES (NUM_EDGES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("epsilon_nfa_acceptor: mismatch");
    $finish;
  end

  task automatic report(string msg);
    err_count++;
    if (err_count <= 40) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic logic [SET_OUT_W-1:0] lambda_close(logic [SET_OUT_W-1:0] set);
    logic [SET_OUT_W-1:0] prev;
    do begin
      prev = set;
      for (int e = 0; e < NUM_EDGES; e++)
        if (edge_tbl[e].valid && edge_tbl[e].lambda && set[edge_tbl[e].src])
          set[edge_tbl[e].dst] = 1'b1;
    end while (set != prev);
    return set;
  endfunction

  function automatic logic [SET_OUT_W-1:0] symbol_step(logic [SET_OUT_W-1:0] set,
                                                       logic [SYM_W-1:0] sym);
    logic [SET_OUT_W-1:0] nxt;
    nxt = '0;
    for (int e = 0; e < NUM_EDGES; e++)
      if (edge_tbl[e].valid && !edge_tbl[e].lambda && edge_tbl[e].sym == sym &&
          set[edge_tbl[e].src])
        nxt[edge_tbl[e].dst] = 1'b1;
    return nxt;
  endfunction

  function automatic verdict_t apply_item(logic [MODE_W-1:0] mode, in_item_t it);
    verdict_t v;
    case (mode)
      MODE_EDGE: begin
        edge_tbl[it.edge_slot].valid  = it.edge_enable;
        edge_tbl[it.edge_slot].lambda = it.edge_lambda;
        edge_tbl[it.edge_slot].src    = it.edge_source;
        edge_tbl[it.edge_slot].dst    = it.edge_target;
        edge_tbl[it.edge_slot].sym    = it.edge_symbol;
      end
      MODE_BEGIN:   cur_set = lambda_close(16'd1 << start_reg);
      MODE_CONSUME: cur_set = lambda_close(symbol_step(cur_set, it.symbol));
      default: ;
    endcase
    v.accepted   = |(cur_set & accept_reg);
    v.active_set = cur_set;
    v.dead       = (cur_set == '0);
    return v;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it = $urandom;
    it.pad = 1'b0;
    return it;
  endfunction

  // Mostly states from a small pool and symbols from a small alphabet, so words go deep
  function automatic in_item_t rand_edge(logic [STATE_W-1:0] pool_hi);
    in_item_t it;
    it = rand_item();
    it.edge_source = STATE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) :
                                                            $urandom_range(0, pool_hi));
    it.edge_target = STATE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) :
                                                            $urandom_range(0, pool_hi));
    it.edge_lambda = ($urandom_range(0, 3) == 0);
    it.edge_enable = ($urandom_range(0, 6) != 0);
    if (!it.edge_lambda && $urandom_range(0, 19) != 0)
      it.edge_symbol = alphabet[$urandom_range(0, 3)];
    return it;
  endfunction

  task automatic send_item(logic [MODE_W-1:0] mode, in_item_t it);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= it;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    pending_verdicts = {pending_verdicts, apply_item(mode, it)};
  endtask

  task automatic write_edge(logic [SLOT_W-1:0] slot, logic [STATE_W-1:0] src,
                            logic [STATE_W-1:0] dst, logic [SYM_W-1:0] sym,
                            logic lam, logic en);
    in_item_t it;
    it = rand_item();
    it.edge_slot   = slot;
    it.edge_source = src;
    it.edge_target = dst;
    it.edge_symbol = sym;
    it.edge_lambda = lam;
    it.edge_enable = en;
    send_item(MODE_EDGE, it);
  endtask

  task automatic consume(logic [SYM_W-1:0] sym);
    in_item_t it;
    it = rand_item();
    it.symbol = sym;
    send_item(MODE_CONSUME, it);
  endtask

  // Drop valid and hold until every pending beat has come back
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_START) start_reg = data[STATE_W-1:0];
    else if (idx == CFG_ACCEPT) accept_reg = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Default registers: consume from the empty set, spare mode, then a bare begin
  task automatic test_after_reset();
    consume(8'h00);
    send_item(MODE_SPARE, rand_item());
    send_item(MODE_BEGIN, rand_item());
  endtask

  task automatic test_edge_cases();
    set_reg(CFG_START, 16'hFFFF);
    set_reg(CFG_ACCEPT, 16'h8001);
    write_edge(5'd0, 4'd15, 4'd0, 8'hFF, 1'b0, 1'b1);
    write_edge(5'd31, 4'd0, 4'd7, 8'h5A, 1'b1, 1'b1);
    // lambda edge whose symbol must not act as a symbol edge
    write_edge(5'd5, 4'd7, 4'd15, 8'h00, 1'b1, 1'b1);
    write_edge(5'd6, 4'd0, 4'd3, 8'h00, 1'b0, 1'b0);
    send_item(MODE_BEGIN, rand_item());
    consume(8'hFF);
    consume(8'h00);
    consume(8'hFF);
    write_edge(5'd6, 4'd0, 4'd3, 8'h00, 1'b0, 1'b1);
    send_item(MODE_BEGIN, rand_item());
    consume(8'hFF);
    consume(8'h00);
    write_edge(5'd31, 4'd0, 4'd7, 8'h5A, 1'b1, 1'b0);
    send_item(MODE_SPARE, rand_item());
    send_item(MODE_BEGIN, rand_item());
    consume(8'hFF);
    write_edge(5'd1, 4'd0, 4'd0, 8'h80, 1'b0, 1'b1);
    consume(8'h80);
    consume(8'h7F);
  endtask

  task automatic test_random_words(int phases, int per_phase);
    logic [STATE_W-1:0]    pool_hi;
    logic [STATE_W-1:0]    start_v;
    logic [CFG_DATA_W-1:0] accept_v;
    logic [MODE_W-1:0]     mode;
    in_item_t              it;
    int                    word_left;
    int                    pick;
    for (int p = 0; p < phases; p++) begin
      foreach (alphabet[i]) alphabet[i] = SYM_W'($urandom_range(0, 255));
      pool_hi = STATE_W'($urandom_range(3, 15));
      start_v = STATE_W'($urandom_range(0, pool_hi));
      accept_v = CFG_DATA_W'($urandom & $urandom);
      if (p == 0) begin
        start_v  = 4'd0;
        accept_v = 16'hFFFF;
      end else if (p == 1) begin
        start_v  = 4'd15;
        accept_v = 16'h0000;
      end
      set_reg(CFG_START, {12'($urandom_range(0, 4095)), start_v});
      set_reg(CFG_ACCEPT, accept_v);
      repeat ($urandom_range(6, 16)) send_item(MODE_EDGE, rand_edge(pool_hi));
      word_left = 0;
      repeat (per_phase) begin
        pick = $urandom_range(0, 99);
        it = rand_item();
        if (pick < 3) begin
          mode = MODE_SPARE;
        end else if (pick < 10) begin
          mode = MODE_EDGE;
          it = rand_edge(pool_hi);
        end else if (word_left == 0) begin
          mode = MODE_BEGIN;
          word_left = $urandom_range(0, 8);
        end else begin
          mode = MODE_CONSUME;
          if (pick >= 15) it.symbol = alphabet[$urandom_range(0, 3)];
          word_left--;
        end
        send_item(mode, it);
      end
    end
  endtask

  // Receiver: ready runs broken by stalls, now and then a long open stretch
  initial begin
    int run;
    out_tready = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 10);
      repeat (run) begin
        @(negedge clk);
        out_tready <= 1'b1;
      end
      if ($urandom_range(0, 4) != 0) begin
        run = $urandom_range(1, 6);
        repeat (run) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    verdict_t got;
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(verdict_t)-1:0];
      if (pending_verdicts.size() == 0) begin
        report($sformatf("result beat %h with nothing pending", out_tdata));
      end else begin
        want = pending_verdicts.pop_front();
        if (got.accepted !== want.accepted)
          report($sformatf("accepted %b, want %b", got.accepted, want.accepted));
        if (got.active_set !== want.active_set)
          report($sformatf("active_set %h, want %h", got.active_set, want.active_set));
        if (got.dead !== want.dead)
          report($sformatf("dead %b, want %b", got.dead, want.dead));
        if (out_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0)
          report($sformatf("pad bits %h not zero", out_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]));
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    err_count  = 0;
    burst_left = 0;
    start_reg  = '0;
    accept_reg = '0;
    cur_set    = '0;
    foreach (edge_tbl[e]) edge_tbl[e] = '0;
    foreach (alphabet[i]) alphabet[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_edge_cases();
    test_random_words(10, 195);

    wait_idle();
    repeat (30) @(posedge clk);
    if (pending_verdicts.size() != 0)
      report($sformatf("%0d results never arrived", pending_verdicts.size()));
    if (err_count == 0) begin
      $display("epsilon_nfa_acceptor: match");
    end else begin
      $display("epsilon_nfa_acceptor: mismatch");
    end
    $finish;
  end

endmodule
